>>> rtl/weighted_vertex_skinning_core_assert.svh
// Assertion macros for the vertex skinning core.
// Used by the top-level core module; depends on nothing else.
`ifndef WEIGHTED_VERTEX_SKINNING_CORE_ASSERT_SVH
`define WEIGHTED_VERTEX_SKINNING_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define WVS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define WVS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define WVS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WVS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/wvs_pkg.sv
// Package of the vertex skinning core: payload types, sequencer states, constants, rounding functions.
// Depends on nothing.
package wvs_pkg;
    localparam int MAX_JOINTS_DEF  = 256;
    localparam int MAX_WEIGHTS_DEF = 4;
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_WEIGHT = 1'b1;

    // Step codes of the shared multiply unit.
    localparam logic [1:0] SEL_CROSS = 2'd0;
    localparam logic [1:0] SEL_ROT   = 2'd1;
    localparam logic [1:0] SEL_SCALE = 2'd2;

    typedef struct packed {
        logic               op;
        logic [7:0]         joint_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] bias;
        logic               last_weight;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] vert_x;
        logic signed [31:0] vert_y;
        logic signed [31:0] vert_z;
        logic [2:0]         weight_count;
        logic               too_many_weights;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_CROSS1, ST_CROSS2, ST_SCALE, ST_ACC, ST_OUT
    } t_state;

    // Round half up: floor((a + 2^(k-1)) / 2^k), k = 13 or 14.
    function automatic logic signed [63:0] rnd13(input logic signed [63:0] a);
        logic signed [63:0] v;
        v = a + 64'sd4096;
        return v >>> 13;
    endfunction
    function automatic logic signed [63:0] rnd14(input logic signed [63:0] a);
        logic signed [63:0] v;
        v = a + 64'sd8192;
        return v >>> 14;
    endfunction
endpackage

>>> rtl/weighted_vertex_skinning_core.sv
// Top level of the vertex skinning core: joint memory, sequencer, accumulators.
// Depends on wvs_pkg, wvs_rot_unit and the assertion header.
//
//  channel | direction | handshake            | payload
//  in      | input     | i_in_valid/o_in_ready | wvs_pkg::t_in_item
//  out     | output    | o_out_valid/i_out_ready | wvs_pkg::t_out_item
//
// A joint load is taken in the idle state. A weight steps through the accept with the memory read,
// the limit check, the cross product, the rotation sum, the position sum with the bias scale and
// the saturating add; a weight past the limit ends after the limit check. A last weight then
// enters the output state, which loads the output register, and waits there while the output stalls.
// Reset is synchronous and clears the sequencer, accumulators and output valid;
// the joint memory has no reset.
`include "weighted_vertex_skinning_core_assert.svh"
module weighted_vertex_skinning_core #(
    parameter int MAX_JOINTS  = wvs_pkg::MAX_JOINTS_DEF,
    parameter int MAX_WEIGHTS = wvs_pkg::MAX_WEIGHTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  wvs_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output wvs_pkg::t_out_item o_out_item
);
    import wvs_pkg::*;
    localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int CW = $clog2(MAX_WEIGHTS + 1);

    // Joint memory: one write port, one registered read port.
    logic [31:0] mem_px [MAX_JOINTS];
    logic [31:0] mem_py [MAX_JOINTS];
    logic [31:0] mem_pz [MAX_JOINTS];
    logic [63:0] mem_q  [MAX_JOINTS];
    logic [31:0] r_jpx, r_jpy, r_jpz;
    logic [63:0] r_jq;

    t_state r_state, n_state;
    t_in_item r_item;
    logic r_ok;
    logic signed [31:0] r_acc_x, r_acc_y, r_acc_z;
    logic [CW-1:0] r_seen;
    logic r_ovf;
    logic [1:0] sel;
    logic signed [15:0] ux, uy, uz, uw;
    logic signed [39:0] vx, vy, vz, rx, ry, rz;
    logic in_ok;
    logic [AW-1:0] in_addr;

    // An index past the table reads as an all-zero joint.
    assign in_ok   = 32'(i_in_item.joint_index) < MAX_JOINTS;
    assign in_addr = AW'(i_in_item.joint_index);
    assign o_in_ready = (r_state == ST_IDLE);

    // The joint read is captured with the item and held for the whole weight.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready && in_ok && i_in_item.op == OP_LOAD) begin
            mem_px[in_addr] <= i_in_item.pos_x;
            mem_py[in_addr] <= i_in_item.pos_y;
            mem_pz[in_addr] <= i_in_item.pos_z;
            mem_q[in_addr]  <= {i_in_item.quat_w, i_in_item.quat_z,
                                i_in_item.quat_y, i_in_item.quat_x};
        end
        if (i_in_valid && o_in_ready) begin
            r_jpx  <= mem_px[in_addr];
            r_jpy  <= mem_py[in_addr];
            r_jpz  <= mem_pz[in_addr];
            r_jq   <= mem_q[in_addr];
            r_item <= i_in_item;
            r_ok   <= in_ok;
        end
    end

    // Zero the joint when out of range.
    logic [63:0] jq;
    logic signed [31:0] jpx, jpy, jpz;
    assign jq  = r_ok ? r_jq : '0;
    assign jpx = r_ok ? r_jpx : '0;
    assign jpy = r_ok ? r_jpy : '0;
    assign jpz = r_ok ? r_jpz : '0;
    assign ux = jq[15:0];
    assign uy = jq[31:16];
    assign uz = jq[47:32];
    assign uw = jq[63:48];

    always_comb begin
        sel = SEL_CROSS;
        vx = 40'(r_item.pos_x);
        vy = 40'(r_item.pos_y);
        vz = 40'(r_item.pos_z);
        unique case (r_state)
            ST_CROSS2: begin
                sel = SEL_ROT;
                vx = rx;
                vy = ry;
                vz = rz;
            end
            ST_SCALE: begin
                // Sum s = joint position + v + rotation term.
                sel = SEL_SCALE;
                vx = 40'(jpx) + 40'(r_item.pos_x) + rx;
                vy = 40'(jpy) + 40'(r_item.pos_y) + ry;
                vz = 40'(jpz) + 40'(r_item.pos_z) + rz;
            end
            default: ;
        endcase
    end

    wvs_rot_unit u_rot (
        .i_clk (i_clk), .i_sel (sel),
        .i_ux (ux), .i_uy (uy), .i_uz (uz), .i_uw (uw), .i_bias (r_item.bias),
        .i_vx (vx), .i_vy (vy), .i_vz (vz),
        .o_rx (rx), .o_ry (ry), .o_rz (rz)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid && i_in_item.op == OP_WEIGHT) begin
                n_state = ST_READ;
            end
            ST_READ: begin
                if (32'(r_seen) >= MAX_WEIGHTS) begin
                    n_state = r_item.last_weight ? ST_OUT : ST_IDLE;
                end else begin
                    n_state = ST_CROSS1;
                end
            end
            ST_CROSS1: n_state = ST_CROSS2;
            ST_CROSS2: n_state = ST_SCALE;
            ST_SCALE:  n_state = ST_ACC;
            ST_ACC:    n_state = r_item.last_weight ? ST_OUT : ST_IDLE;
            ST_OUT:    if (!o_out_valid || i_out_ready) begin
                n_state = ST_IDLE;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    function automatic logic signed [31:0] sat(input logic signed [31:0] a,
                                               input logic signed [39:0] d);
        logic signed [40:0] s;
        s = 41'(a) + 41'(d);
        if (s > 41'sh07fffffff) return 32'sh7fffffff;
        if (s < -41'sh080000000) return 32'sh80000000;
        return s[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_acc_x <= '0;
            r_acc_y <= '0;
            r_acc_z <= '0;
            r_seen  <= '0;
            r_ovf   <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_READ && 32'(r_seen) >= MAX_WEIGHTS) r_ovf <= 1'b1;
            if (r_state == ST_ACC) begin
                r_acc_x <= sat(r_acc_x, rx);
                r_acc_y <= sat(r_acc_y, ry);
                r_acc_z <= sat(r_acc_z, rz);
                r_seen  <= r_seen + 1'b1;
            end
            if (r_state == ST_OUT && (!o_out_valid || i_out_ready)) begin
                o_out_valid <= 1'b1;
                o_out_item.vert_x <= r_acc_x;
                o_out_item.vert_y <= r_acc_y;
                o_out_item.vert_z <= r_acc_z;
                o_out_item.weight_count <= (32'(r_seen) > 7) ? 3'd7 : 3'(r_seen);
                o_out_item.too_many_weights <= r_ovf;
                r_acc_x <= '0;
                r_acc_y <= '0;
                r_acc_z <= '0;
                r_seen  <= '0;
                r_ovf   <= 1'b0;
            end else if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    `WVS_ASSERT_IMP(a_cnt_cap, i_clk, i_rst_n, 1'b1, 32'(r_seen) <= MAX_WEIGHTS)
    `WVS_ASSERT_NXT(a_out_seq, i_clk, i_rst_n, !o_out_valid && r_state != ST_OUT, !o_out_valid)
    `WVS_ASSERT_NXT(a_busy, i_clk, i_rst_n, r_state == ST_CROSS1, r_state == ST_CROSS2 && !o_in_ready)
endmodule

>>> rtl/wvs_rot_unit.sv
// Shared arithmetic unit: three lanes of one 16x40 multiply-sum step per cycle.
// Depends on wvs_pkg.
module wvs_rot_unit (
    input  logic                i_clk,
    input  logic [1:0]          i_sel,
    input  logic signed [15:0]  i_ux,
    input  logic signed [15:0]  i_uy,
    input  logic signed [15:0]  i_uz,
    input  logic signed [15:0]  i_uw,
    input  logic signed [15:0]  i_bias,
    input  logic signed [39:0]  i_vx,
    input  logic signed [39:0]  i_vy,
    input  logic signed [39:0]  i_vz,
    output logic signed [39:0]  o_rx,
    output logic signed [39:0]  o_ry,
    output logic signed [39:0]  o_rz
);
    import wvs_pkg::*;

    logic signed [63:0] n_x, n_y, n_z;
    logic signed [63:0] vx, vy, vz;

    always_comb begin
        vx = 64'(i_vx);
        vy = 64'(i_vy);
        vz = 64'(i_vz);
        n_x = '0;
        n_y = '0;
        n_z = '0;
        unique case (i_sel)
            SEL_CROSS: begin
                n_x = rnd13(i_uy * vz - i_uz * vy);
                n_y = rnd13(i_uz * vx - i_ux * vz);
                n_z = rnd13(i_ux * vy - i_uy * vx);
            end
            SEL_ROT: begin
                n_x = rnd14(i_uw * vx + i_uy * vz - i_uz * vy);
                n_y = rnd14(i_uw * vy + i_uz * vx - i_ux * vz);
                n_z = rnd14(i_uw * vz + i_ux * vy - i_uy * vx);
            end
            SEL_SCALE: begin
                n_x = rnd14(i_bias * vx);
                n_y = rnd14(i_bias * vy);
                n_z = rnd14(i_bias * vz);
            end
            default: begin
                n_x = vx;
                n_y = vy;
                n_z = vz;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_rx <= n_x[39:0];
        o_ry <= n_y[39:0];
        o_rz <= n_z[39:0];
    end
endmodule
